// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while in reset.
`define IC3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while in reset.
`define IC3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ic3_pkg.sv =====
`timescale 1ns / 1ps
package ic3_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int KERNEL_TAPS  = 3;
  localparam int NUM_TAPS     = KERNEL_TAPS * KERNEL_TAPS;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W      = 12;
  localparam int HEIGHT_W     = 13;
  localparam int CHAN_W       = 3;
  localparam int COL_W        = 12;
  localparam int ROW_W        = 13;
  localparam int IDX_W        = 26;
  localparam int PIX_W        = 32;
  localparam int KROW_W       = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = 25;
  localparam int SUM_W        = 28;
  localparam int FRAC_W       = 8;
  localparam int Q_W          = SUM_W - FRAC_W;
  localparam int BYTE_MAX     = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_ROW0   = 3'd0,
    CFG_KERNEL_ROW1   = 3'd1,
    CFG_KERNEL_ROW2   = 3'd2,
    CFG_CLAMP_MODE    = 3'd3,
    CFG_IMAGE_WIDTH   = 3'd4,
    CFG_IMAGE_HEIGHT  = 3'd5,
    CFG_CHANNEL_COUNT = 3'd6
  } cfg_idx_t;

  typedef logic [7:0] byte_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic  kind;
    byte_t in_ch0;
    byte_t in_ch1;
    byte_t in_ch2;
    byte_t in_ch3;
  } in_item_t;

  typedef struct packed {
    byte_t out_ch0;
    byte_t out_ch1;
    byte_t out_ch2;
    byte_t out_ch3;
    logic  frame_end;
  } out_item_t;

endpackage

// ===== hdl/ic3_ram.sv =====
`timescale 1ns / 1ps
module ic3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ic3_lane.sv =====
`timescale 1ns / 1ps
module ic3_lane import ic3_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  byte_t tap [NUM_TAPS],
  input  coef_t coef [NUM_TAPS],
  input  logic  clamp_mode,
  output byte_t result
);

  logic signed [PROD_W-1:0] prod_r [NUM_TAPS];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  biased;
  logic signed [Q_W-1:0]    q;
  byte_t                    result_r;
  byte_t                    result_nxt;

  // sum of nine products
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      sum_nxt = sum_nxt + {{(SUM_W-PROD_W){prod_r[i][PROD_W-1]}}, prod_r[i]};
    end
  end

  // divide by 256 toward zero, then wrap or clamp
  always_comb begin
    biased = sum_r[SUM_W-1] ? sum_r + SUM_W'(BYTE_MAX) : sum_r;
    q      = biased[SUM_W-1:FRAC_W];
    if (clamp_mode) begin
      if (q < 0) begin
        result_nxt = '0;
      end else if (q > Q_W'(BYTE_MAX)) begin
        result_nxt = 8'(BYTE_MAX);
      end else begin
        result_nxt = q[7:0];
      end
    end else begin
      result_nxt = q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        prod_r[i] <= coef[i] * $signed({1'b0, tap[i]});
      end
      sum_r    <= sum_nxt;
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// ===== hdl/ic3_merge.sv =====
`timescale 1ns / 1ps
module ic3_merge import ic3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output logic      skid_full
);

  logic      out_v_r, out_v_nxt;
  logic      sk_v_r, sk_v_nxt;
  out_item_t out_d_r, sk_d_r;
  logic      out_free;

  assign out_free = !out_v_r || out_ready;

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    if (out_free) begin
      out_v_nxt = sk_v_r || push;
      sk_v_nxt  = 1'b0;
    end else if (push) begin
      sk_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
    if (out_free) begin
      out_d_r <= sk_v_r ? sk_d_r : push_item;
    end else if (push) begin
      sk_d_r <= push_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_d_r;
  assign skid_full = sk_v_r;

endmodule

// ===== hdl/image_conv3x3_filter.sv =====
`timescale 1ns / 1ps
// 3x3 convolution over raster-order pixels of up to four 8-bit channels.
// Input channel in_*: one item per pixel (kind 0), then drain items (kind 1)
// once the image has ended; width+1 drain items flush the last results.
// Result channel out_*: one filtered pixel, frame_end set on the last one.
// Configuration channel cfg_*: kernel rows, clamp mode, size and channel count;
// write only while the block is idle. cfg_ready is always high.
// Throughput: one item per cycle unless the skid stage is full. After a write
// of image_width the block holds in_ready low for one cycle while the row
// offset products refresh. Pipeline: the item that completes a window passes
// the line buffer read, window, multiply, adder tree and rounding registers,
// then the result waits in the output register.
// Reset (synchronous, rst_n low): counters, window and handshakes clear,
// registers take their defaults. Line buffers keep stale contents; those
// entries only feed taps outside the image, which use the centre pixel.
// Receiver stall: an output register plus a one-item skid stage; the whole
// pipeline freezes only once the skid stage is full.
module image_conv3x3_filter import ic3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KROW_W-1:0]    cfg_data
);

`include "assert_macros.svh"

  typedef struct packed {
    logic emit;
    logic fend;
    logic top;
    logic bot;
    logic left;
    logic right;
  } emit_info_t;

  // configuration registers
  logic [KROW_W-1:0]   kernel_r [KERNEL_TAPS];
  logic                clamp_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CHAN_W-1:0]   nch_r;
  logic                stale_r;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [CHAN_W-1:0]   nch_eff;

  // stream counters and their row offsets (row * width)
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [IDX_W-1:0]  pin_r, pin_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [IDX_W-1:0]  pout_r, pout_nxt;

  logic              adv, accept, process;
  logic              skid_full;
  logic [COL_W-1:0]  col_a, col_b, col_n;
  logic [ROW_W-1:0]  row_a;
  logic [IDX_W-1:0]  pin_a, absorbed, target;
  logic              wrap_a, wrap_b;
  emit_info_t        info_nxt;
  logic [PIX_W-1:0]  pix;

  // stage 1: line buffer read
  logic              s1_v_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [PIX_W-1:0]  s1_pix_r;
  emit_info_t        s1_info_r;
  logic              fwd_r;
  logic [PIX_W-1:0]  fwd_near_r, fwd_far_r;
  logic [PIX_W-1:0]  near_q, far_q, s1_near, s1_far;

  // stage 2 onwards
  logic [PIX_W-1:0]  win_r [NUM_TAPS];
  logic              v2_r, v3_r, v4_r, v5_r;
  emit_info_t        info2_r;
  logic              f3_r, f4_r, f5_r;
  logic [PIX_W-1:0]  tap_word [NUM_TAPS];
  byte_t             lane_tap [MAX_CHANNELS][NUM_TAPS];
  coef_t             coef [NUM_TAPS];
  byte_t             lane_res [MAX_CHANNELS];
  byte_t             res_mask [MAX_CHANNELS];
  out_item_t         push_item;

  // clamp out-of-range settings
  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    if (nch_r == '0) begin
      nch_eff = CHAN_W'(1);
    end else if (nch_r > CHAN_W'(MAX_CHANNELS)) begin
      nch_eff = CHAN_W'(MAX_CHANNELS);
    end else begin
      nch_eff = nch_r;
    end
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KERNEL_TAPS; i++) begin
        kernel_r[i] <= '0;
      end
      clamp_r  <= 1'b0;
      width_r  <= WIDTH_W'(MAX_WIDTH);
      height_r <= HEIGHT_W'(1);
      nch_r    <= CHAN_W'(3);
      stale_r  <= 1'b0;
    end else begin
      stale_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_KERNEL_ROW0:   kernel_r[0] <= cfg_data;
          CFG_KERNEL_ROW1:   kernel_r[1] <= cfg_data;
          CFG_KERNEL_ROW2:   kernel_r[2] <= cfg_data;
          CFG_CLAMP_MODE:    clamp_r <= cfg_data[0];
          CFG_IMAGE_WIDTH: begin
            width_r <= cfg_data[WIDTH_W-1:0];
            stale_r <= 1'b1;
          end
          CFG_IMAGE_HEIGHT:  height_r <= cfg_data[HEIGHT_W-1:0];
          CFG_CHANNEL_COUNT: nch_r <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // handshake: advance unless the skid stage holds an item; input also waits out an offset refresh
  assign adv      = !skid_full;
  assign in_ready = !skid_full && !stale_r;
  assign accept   = in_valid && in_ready;

  // stream position bookkeeping for the accepted item
  always_comb begin
    wrap_a   = in_col_r >= w_eff;
    col_a    = wrap_a ? '0 : in_col_r;
    row_a    = in_row_r + ROW_W'(wrap_a);
    pin_a    = pin_r + (wrap_a ? IDX_W'(w_eff) : '0);
    process  = in_item.kind == (row_a >= h_eff);
    col_b    = col_a + COL_W'(1);
    wrap_b   = col_b >= w_eff;
    col_n    = wrap_b ? '0 : col_b;
    absorbed = pin_a + (wrap_b ? IDX_W'(w_eff) : '0) + IDX_W'(col_n);
    target   = pout_r + IDX_W'(out_col_r) + IDX_W'(w_eff) + IDX_W'(2);

    info_nxt.emit  = process && (absorbed >= target);
    info_nxt.fend  = (out_row_r + ROW_W'(1) >= ROW_W'(h_eff)) &&
                     (out_col_r + COL_W'(1) >= w_eff);
    info_nxt.top   = out_row_r == '0;
    info_nxt.bot   = out_row_r + ROW_W'(1) >= ROW_W'(h_eff);
    info_nxt.left  = out_col_r == '0;
    info_nxt.right = out_col_r + COL_W'(1) >= w_eff;

    in_col_nxt  = col_a;
    in_row_nxt  = row_a;
    pin_nxt     = pin_a;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pout_nxt    = pout_r;
    if (process) begin
      in_col_nxt = col_n;
      in_row_nxt = row_a + ROW_W'(wrap_b);
      pin_nxt    = pin_a + (wrap_b ? IDX_W'(w_eff) : '0);
    end
    if (info_nxt.emit) begin
      if (out_col_r + COL_W'(1) >= w_eff) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + ROW_W'(1);
        pout_nxt    = pout_r + IDX_W'(w_eff);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
      if (info_nxt.fend) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        pin_nxt     = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        pout_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      pin_r     <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pout_r    <= '0;
    end else if (stale_r) begin
      // rebuild the row offsets against the new width
      pin_r  <= IDX_W'(in_row_r) * IDX_W'(w_eff);
      pout_r <= IDX_W'(out_row_r) * IDX_W'(w_eff);
    end else if (accept) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      pin_r     <= pin_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pout_r    <= pout_nxt;
    end
  end

  // drain items shift in a zero pixel
  assign pix = in_item.kind ? '0 :
               {in_item.in_ch3, in_item.in_ch2, in_item.in_ch1, in_item.in_ch0};

  // line buffers: near holds the previous row, far the one before
  ic3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_near (
    .clk   (clk),
    .we    (adv && s1_v_r),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (col_a[ADDR_W-1:0]),
    .rdata (near_q)
  );

  ic3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_far (
    .clk   (clk),
    .we    (adv && s1_v_r),
    .waddr (s1_addr_r),
    .wdata (s1_near),
    .re    (accept),
    .raddr (col_a[ADDR_W-1:0]),
    .rdata (far_q)
  );

  // forward the write in flight when a one-pixel-wide row rereads its column
  assign s1_near = fwd_r ? fwd_near_r : near_q;
  assign s1_far  = fwd_r ? fwd_far_r  : far_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept && process;
      fwd_r  <= accept && process && s1_v_r && (s1_addr_r == col_a[ADDR_W-1:0]);
    end
    if (accept) begin
      s1_addr_r  <= col_a[ADDR_W-1:0];
      s1_pix_r   <= pix;
      s1_info_r  <= info_nxt;
      fwd_near_r <= s1_pix_r;
      fwd_far_r  <= s1_near;
    end
  end

  // window: index age*3 + row slot, row slot 0 the oldest row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        win_r[i] <= '0;
      end
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      if (s1_v_r) begin
        for (int i = 0; i < KERNEL_TAPS; i++) begin
          win_r[6+i] <= win_r[3+i];
          win_r[3+i] <= win_r[i];
        end
        win_r[0] <= s1_far;
        win_r[1] <= s1_near;
        win_r[2] <= s1_pix_r;
      end
      v2_r <= s1_v_r && s1_info_r.emit;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info2_r <= s1_info_r;
      f3_r    <= info2_r.fend;
      f4_r    <= f3_r;
      f5_r    <= f4_r;
    end
  end

  // pick taps; any tap off the image takes the centre pixel
  always_comb begin
    for (int ky = 0; ky < KERNEL_TAPS; ky++) begin
      for (int kx = 0; kx < KERNEL_TAPS; kx++) begin
        if ((ky == 0 && info2_r.bot) || (ky == 2 && info2_r.top) ||
            (kx == 0 && info2_r.right) || (kx == 2 && info2_r.left)) begin
          tap_word[ky*KERNEL_TAPS+kx] = win_r[4];
        end else begin
          tap_word[ky*KERNEL_TAPS+kx] = win_r[kx*KERNEL_TAPS + (2-ky)];
        end
        coef[ky*KERNEL_TAPS+kx] = kernel_r[ky][COEF_W*kx +: COEF_W];
      end
    end
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        lane_tap[ch][i] = tap_word[i][8*ch +: 8];
      end
    end
  end

  // one lane per channel
  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
    ic3_lane u_lane (
      .clk        (clk),
      .adv        (adv),
      .tap        (lane_tap[ch]),
      .coef       (coef),
      .clamp_mode (clamp_r),
      .result     (lane_res[ch])
    );
  end

  // merge lanes; channels not in use give zero
  always_comb begin
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      res_mask[ch] = (CHAN_W'(ch) < nch_eff) ? lane_res[ch] : '0;
    end
    push_item.out_ch0   = res_mask[0];
    push_item.out_ch1   = res_mask[1];
    push_item.out_ch2   = res_mask[2];
    push_item.out_ch3   = res_mask[3];
    push_item.frame_end = f5_r;
  end

  ic3_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (v5_r && adv),
    .push_item (push_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .skid_full (skid_full)
  );

  `IC3_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_full, out_valid, "skid holds item while output empty")
  `IC3_ASSERT_NOW(a_stale_blocks_in, clk, rst_n, stale_r, !in_ready, "item accepted during offset refresh")
  `IC3_ASSERT_NOW(a_fwd_needs_s1, clk, rst_n, fwd_r, s1_v_r, "forward flag without a write in flight")
  `IC3_ASSERT_NEXT(a_width_refresh, clk, rst_n, cfg_valid && cfg_index == CFG_IMAGE_WIDTH, stale_r, "width write without refresh")

endmodule

// ===== dv/image_conv3x3_filter_tb.sv =====
`timescale 1ns / 1ps
module image_conv3x3_filter_tb;
  import ic3_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 12;   // pipeline depth plus skid, with margin
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_RESULT = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KERNEL_ROW0;
  logic [KROW_W-1:0] cfg_data = '0;

  image_conv3x3_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies held by the predictor, reset values of the block
  logic [KROW_W-1:0] kern_row [3] = '{default: '0};
  bit   clamp_on = 1'b0;
  int   width_reg = 2048;
  int   height_reg = 1;
  int   chan_reg = 3;

  // Filter state mirrored from the block
  logic [31:0] line_near [MAX_WIDTH];
  logic [31:0] line_far [MAX_WIDTH];
  logic [31:0] win [9] = '{default: '0};
  int   in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  in_item_t  pending_px [$];   // items waiting for the driver
  out_item_t expected_px [$];  // filtered pixels not yet seen

  int  fails = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  images_done = 0;
  int  cycles = 0;
  bit  src_steady = 1'b0;     // no source gaps while set
  bit  snk_steady = 1'b0;     // no random sink stalls while set

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_near[i] = '0;
      line_far[i] = '0;
    end
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the filter by one item; return 1 when it yields a filtered pixel.
  function automatic bit conv_step(input in_item_t it, output out_item_t res);
    int w, h, nch, c, y, x, r, cc, sum, q;
    logic [31:0] pix, f, nr, word;
    logic [7:0] b [4];
    coef_t cf;
    longint absorbed, outidx;
    bit fend;
    w = clip(width_reg, 1, MAX_WIDTH);
    h = clip(height_reg, 1, MAX_HEIGHT);
    nch = clip(chan_reg, 1, MAX_CHANNELS);
    res = '0;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    // drop pixels while draining and drains during the image
    if ((in_row >= h) != it.kind) return 1'b0;
    pix = it.kind ? 32'd0 : {it.in_ch3, it.in_ch2, it.in_ch1, it.in_ch0};
    c = in_col;
    f = line_far[c];
    nr = line_near[c];
    line_far[c] = nr;
    line_near[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[6+i] = win[3+i];
      win[3+i] = win[i];
    end
    win[0] = f;
    win[1] = nr;
    win[2] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    absorbed = longint'(in_row) * w + in_col;
    outidx = longint'(out_row) * w + out_col;
    if (absorbed < outidx + w + 2) return 1'b0;
    y = out_row;
    x = out_col;
    for (int ch = 0; ch < 4; ch++) begin
      b[ch] = '0;
      if (ch < nch) begin
        sum = 0;
        for (int ky = 0; ky < KERNEL_TAPS; ky++) begin
          for (int kx = 0; kx < KERNEL_TAPS; kx++) begin
            r = y + 1 - ky;
            cc = x + 1 - kx;
            // taps off the image take the centre pixel
            if (r >= 0 && r < h && cc >= 0 && cc < w) word = win[kx*3 + (2-ky)];
            else word = win[4];
            cf = coef_t'(kern_row[ky][16*kx +: 16]);
            sum += int'(cf) * int'({24'd0, word[8*ch +: 8]});
          end
        end
        q = sum / 256;
        if (clamp_on) b[ch] = 8'(clip(q, 0, BYTE_MAX));
        else b[ch] = q[7:0];
      end
    end
    fend = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.out_ch0 = b[0];
    res.out_ch1 = b[1];
    res.out_ch2 = b[2];
    res.out_ch3 = b[3];
    res.frame_end = fend;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (fend) begin
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Source: offer the next pending item, hold it until taken, then maybe idle.
  int src_gap = 0;
  always @(posedge clk) begin
    out_item_t res;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (conv_step(in_item, res)) expected_px.push_back(res);
      end
      if (in_valid && !in_ready) begin
        // hold item and payload
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_px.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_px.pop_front();
        src_gap <= src_steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink: random stalls, one long hold-off once results are flowing.
  int  snk_hold = 0;
  bit  held_long = 1'b0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_px.size() == 0) begin
          $error("unexpected filtered pixel %h", out_item);
          fails++;
        end else begin
          want = expected_px.pop_front();
          if (out_item.out_ch0 !== want.out_ch0) begin
            $error("out_ch0 expected %h got %h", want.out_ch0, out_item.out_ch0);
            fails++;
          end
          if (out_item.out_ch1 !== want.out_ch1) begin
            $error("out_ch1 expected %h got %h", want.out_ch1, out_item.out_ch1);
            fails++;
          end
          if (out_item.out_ch2 !== want.out_ch2) begin
            $error("out_ch2 expected %h got %h", want.out_ch2, out_item.out_ch2);
            fails++;
          end
          if (out_item.out_ch3 !== want.out_ch3) begin
            $error("out_ch3 expected %h got %h", want.out_ch3, out_item.out_ch3);
            fails++;
          end
          if (out_item.frame_end !== want.frame_end) begin
            $error("frame_end expected %b got %b", want.frame_end, out_item.frame_end);
            fails++;
          end
        end
      end
      if (!held_long && results_seen == HOLD_AT_RESULT) begin
        // long back-pressure so the skid fills and in_ready drops
        held_long <= 1'b1;
        snk_hold <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (snk_hold > 0) begin
        snk_hold <= snk_hold - 1;
        out_ready <= 1'b0;
      end else if (!snk_steady && $urandom_range(99) < 30) begin
        snk_hold <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Hold the write channel up until the edge that takes it, then mirror it.
  task automatic write_reg(input cfg_idx_t idx, input logic [KROW_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_KERNEL_ROW0:   kern_row[0] = d;
      CFG_KERNEL_ROW1:   kern_row[1] = d;
      CFG_KERNEL_ROW2:   kern_row[2] = d;
      CFG_CLAMP_MODE:    clamp_on = d[0];
      CFG_IMAGE_WIDTH:   width_reg = int'(d[WIDTH_W-1:0]);
      CFG_IMAGE_HEIGHT:  height_reg = int'(d[HEIGHT_W-1:0]);
      CFG_CHANNEL_COUNT: chan_reg = int'(d[CHAN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic setup_image(input logic [KROW_W-1:0] k0, k1, k2, input bit clamp,
                             input int w, h, nch);
    write_reg(CFG_KERNEL_ROW0, k0);
    write_reg(CFG_KERNEL_ROW1, k1);
    write_reg(CFG_KERNEL_ROW2, k2);
    write_reg(CFG_CLAMP_MODE, KROW_W'(clamp));
    write_reg(CFG_IMAGE_WIDTH, KROW_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, KROW_W'(h));
    write_reg(CFG_CHANNEL_COUNT, KROW_W'(nch));
    cfg_valid <= 1'b0;
  endtask

  // Wait for the whole image to pass, then let the pipeline settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_px.size() > 0 || in_valid || expected_px.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t rand_item(input bit drain);
    in_item_t it;
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    it = {drain, v[7:0], v[15:8], v[23:16], v[31:24]};
    return it;
  endfunction

  // Queue one image plus its drain; noise adds items the block must ignore.
  task automatic queue_image(input bit noise);
    int w, h;
    w = clip(width_reg, 1, MAX_WIDTH);
    h = clip(height_reg, 1, MAX_HEIGHT);
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(19) == 0) pending_px.push_back(rand_item(1'b1));
      pending_px.push_back(rand_item(1'b0));
    end
    for (int i = 0; i <= w; i++) begin
      if (noise && $urandom_range(9) == 0) pending_px.push_back(rand_item(1'b0));
      pending_px.push_back(rand_item(1'b1));
    end
    // a drain after the frame has closed is dropped
    if (noise && $urandom_range(3) == 0) pending_px.push_back(rand_item(1'b1));
    items_sent += w * h + w + 1;
    images_done++;
  endtask

  function automatic logic [KROW_W-1:0] rand_kernel_row(input int flavour);
    logic [KROW_W-1:0] k;
    for (int i = 0; i < 3; i++) begin
      case (flavour)
        0: k[16*i +: 16] = $urandom;
        1: k[16*i +: 16] = 16'($signed($urandom_range(512)) - 256);
        default: k[16*i +: 16] = 16'($signed($urandom_range(64)) - 32);
      endcase
    end
    return k;
  endfunction

  initial begin
    int fl, w, h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size and channel count, max positive taps, wrapped sum
    setup_image({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 1'b0, 0, 0, 0);
    pending_px.push_back('{kind: 1'b1, in_ch0: 8'h00, in_ch1: 8'hff,
                           in_ch2: 8'h00, in_ch3: 8'hff});
    pending_px.push_back('{kind: 1'b0, in_ch0: 8'hff, in_ch1: 8'hff,
                           in_ch2: 8'hff, in_ch3: 8'hff});
    pending_px.push_back('{kind: 1'b1, in_ch0: 8'h00, in_ch1: 8'h00,
                           in_ch2: 8'h00, in_ch3: 8'h00});
    pending_px.push_back('{kind: 1'b0, in_ch0: 8'h55, in_ch1: 8'haa,
                           in_ch2: 8'h55, in_ch3: 8'haa});
    pending_px.push_back('{kind: 1'b1, in_ch0: 8'hff, in_ch1: 8'h00,
                           in_ch2: 8'hff, in_ch3: 8'h00});
    items_sent += 5;
    wait_idle();

    // Directed: most negative taps, clamped to zero, all four channels
    setup_image({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 1'b1, 3, 2, 4);
    queue_image(1'b0);
    wait_idle();

    // Directed: channel count above range, positive taps clamped to 255
    setup_image({3{16'h7fff}}, {16'h0000, 16'h0100, 16'h0000}, {3{16'hff00}},
                1'b1, 3, 2, 7);
    queue_image(1'b0);
    wait_idle();

    // Directed: a larger image, so the long sink hold-off lands mid-stream
    setup_image(rand_kernel_row(1), rand_kernel_row(1), rand_kernel_row(1),
                1'b0, 8, 12, 4);
    queue_image(1'b0);
    wait_idle();

    // Random images, mostly small
    while (items_sent < 1150 + 25) begin
      fl = $urandom_range(2);
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      setup_image(rand_kernel_row(fl), rand_kernel_row(fl), rand_kernel_row(fl),
                  1'($urandom), w, h, $urandom_range(7));
      src_steady = ($urandom_range(4) == 0);
      snk_steady = ($urandom_range(4) == 0);
      queue_image($urandom_range(3) == 0);
      wait_idle();
    end

    $display("tb: %0d images, %0d items offered, %0d filtered pixels checked",
             images_done, items_sent, results_seen);
    $display("tb: wrap and clamp, zero sizes, 1 to 4 channels, stray items, long stall");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
